/* src/mpf_pkg.sv */
// Package for the multilevel priority FIFO: sizes, codes and shared types.
// Used by the channel interfaces, the pointer controller and the top level.
`default_nettype none

package mpf_pkg;

  // Queue geometry
  localparam int LEVELS       = 8;
  localparam int DEPTH        = 16;
  localparam int HANDLE_WIDTH = 16;

  // Fixed field widths of the channels
  localparam int LEVEL_FIELD_W  = 3;
  localparam int HANDLE_FIELD_W = 16;

  // Derived widths
  localparam int LEVEL_W   = $clog2(LEVELS);
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int ADDR_W    = LEVEL_W + IDX_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef logic [LEVEL_W-1:0] lvl_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  // Decision for one beat, from the pointer controller to the datapath
  typedef struct packed {
    logic                     wr_en;
    logic                     rd_en;
    addr_t                    addr;
    status_t                  status;
    logic [LEVEL_FIELD_W-1:0] level;
  } op_t;

  // Circular advance of a FIFO position
  function automatic idx_t next_idx(input idx_t idx);
    idx_t res;
    if (idx == idx_t'(DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + idx_t'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* src/mpf_req_if.sv */
// Request channel of the multilevel priority FIFO (valid/ready plus payload).
// Depends on mpf_pkg for the field types.
`default_nettype none

interface mpf_req_if;
  logic                                 valid;
  logic                                 ready;
  mpf_pkg::opcode_t                     opcode;
  logic [mpf_pkg::LEVEL_FIELD_W-1:0]    level;
  logic [mpf_pkg::HANDLE_FIELD_W-1:0]   handle;

  modport source (output valid, output opcode, output level, output handle, input ready);
  modport sink   (input valid, input opcode, input level, input handle, output ready);
endinterface

`default_nettype wire

/* src/mpf_rsp_if.sv */
// Response channel of the multilevel priority FIFO (valid/ready plus payload).
// Depends on mpf_pkg for the field types.
`default_nettype none

interface mpf_rsp_if;
  logic                                 valid;
  logic                                 ready;
  mpf_pkg::status_t                     status;
  logic [mpf_pkg::HANDLE_FIELD_W-1:0]   out_handle;
  logic [mpf_pkg::LEVEL_FIELD_W-1:0]    out_level;

  modport source (output valid, output status, output out_handle, output out_level,
                  input ready);
  modport sink   (input valid, input status, input out_handle, input out_level,
                  output ready);
endinterface

`default_nettype wire

/* src/mpf_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
`default_nettype none

module mpf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/mpf_ctrl.sv */
// Pointer controller: per-level head, tail and count, level selection and status.
// Depends on mpf_pkg; drives the entry RAM address through an op_t.
`default_nettype none

module mpf_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              accept,
  input  wire mpf_pkg::opcode_t                  opcode,
  input  wire logic [mpf_pkg::LEVEL_FIELD_W-1:0] level,
  output      mpf_pkg::op_t                      op
);

  mpf_pkg::idx_t head  [mpf_pkg::LEVELS];
  mpf_pkg::idx_t tail  [mpf_pkg::LEVELS];
  mpf_pkg::cnt_t count [mpf_pkg::LEVELS];

  mpf_pkg::lvl_t enq_lv;
  mpf_pkg::lvl_t deq_lv;
  logic          deq_found;
  logic          enq_full;

  // Enqueue level, out-of-range levels go to the lowest priority
  always_comb begin
    if (level >= mpf_pkg::LEVEL_FIELD_W'(mpf_pkg::LEVELS - 1) &&
        int'(level) >= mpf_pkg::LEVELS - 1) begin
      enq_lv = mpf_pkg::lvl_t'(mpf_pkg::LEVELS - 1);
    end else begin
      enq_lv = mpf_pkg::lvl_t'(level);
    end
    enq_full = (count[enq_lv] == mpf_pkg::cnt_t'(mpf_pkg::DEPTH));
  end

  // Priority encoder: lowest-numbered non-empty level wins
  always_comb begin
    deq_found = 1'b0;
    deq_lv    = '0;
    for (int i = mpf_pkg::LEVELS - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        deq_found = 1'b1;
        deq_lv    = mpf_pkg::lvl_t'(i);
      end
    end
  end

  // Decision for the current beat
  always_comb begin
    op = '0;
    case (opcode)
      mpf_pkg::OP_ENQ: begin
        op.status = enq_full ? mpf_pkg::ST_FULL : mpf_pkg::ST_OK;
        op.wr_en  = accept && !enq_full;
        op.addr   = {enq_lv, tail[enq_lv]};
      end
      mpf_pkg::OP_DEQ: begin
        op.status = deq_found ? mpf_pkg::ST_OK : mpf_pkg::ST_EMPTY;
        op.rd_en  = accept && deq_found;
        op.addr   = {deq_lv, head[deq_lv]};
        op.level  = deq_found ? mpf_pkg::LEVEL_FIELD_W'(deq_lv) : '0;
      end
      default: begin
        op = '0;
      end
    endcase
  end

  // Pointer and count update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mpf_pkg::LEVELS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      if (op.wr_en) begin
        tail[enq_lv]  <= mpf_pkg::next_idx(tail[enq_lv]);
        count[enq_lv] <= count[enq_lv] + mpf_pkg::cnt_t'(1);
      end
      if (op.rd_en) begin
        head[deq_lv]  <= mpf_pkg::next_idx(head[deq_lv]);
        count[deq_lv] <= count[deq_lv] - mpf_pkg::cnt_t'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* src/multilevel_priority_fifo.sv */
// Multilevel strict-priority FIFO of process handles.
// Depends on mpf_pkg, mpf_req_if, mpf_rsp_if, mpf_ctrl and mpf_ram.
//
// Usage:
//   req channel carries one command per beat: opcode (enqueue/dequeue),
//   level (enqueue only, levels past the last one map to the last one) and
//   handle (enqueue only). rsp channel returns exactly one beat per command:
//   status (ok, level full, all empty), out_handle and out_level, both zero
//   unless a dequeue succeeded. Level 0 is served first.
// Latency: the response is valid the cycle after the command beat.
// Throughput: one command per cycle while rsp is not stalled. Head/tail/count live in per-level
//   registers; handles live in one RAM with a registered read,
//   whose output register holds the dequeued handle until the response leaves.
// Stall: one output register; req.ready is high while it is empty or being
//   drained by rsp.ready, so a stalled receiver stops new commands.
// Reset (rst, synchronous): all levels empty, no response pending. The
//   handle RAM is not cleared; entries are only read after being written.
`default_nettype none

module multilevel_priority_fifo (
  input wire logic clk,
  input wire logic rst,
  mpf_req_if.sink  req,
  mpf_rsp_if.source rsp
);

  logic                                fire;
  mpf_pkg::op_t                        op;
  logic [mpf_pkg::HANDLE_WIDTH-1:0]    rd_data;

  logic                                out_valid;
  mpf_pkg::status_t                    out_status;
  logic [mpf_pkg::LEVEL_FIELD_W-1:0]   out_level;
  logic                                out_from_ram;

  // Handshake
  assign req.ready = !out_valid || rsp.ready;
  assign fire      = req.valid && req.ready;

  mpf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (fire),
    .opcode (req.opcode),
    .level  (req.level),
    .op     (op)
  );

  mpf_ram #(
    .WIDTH (mpf_pkg::HANDLE_WIDTH),
    .DEPTH (mpf_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (op.wr_en),
    .waddr (op.addr),
    .wdata (mpf_pkg::HANDLE_WIDTH'(req.handle)),
    .re    (op.rd_en),
    .raddr (op.addr),
    .rdata (rd_data)
  );

  // Response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_status   <= op.status;
      out_level    <= op.level;
      out_from_ram <= op.rd_en;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.out_level  = out_level;
  assign rsp.out_handle = out_from_ram ? mpf_pkg::HANDLE_FIELD_W'(rd_data) : '0;

  // Checks
  a_fire_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("accepted beat did not produce a response");

  a_no_wr_and_rd: assert property (@(posedge clk) disable iff (rst)
    !(op.wr_en && op.rd_en))
    else $error("RAM written and read in the same beat");

  a_fail_no_change: assert property (@(posedge clk) disable iff (rst)
    fire && op.status != mpf_pkg::ST_OK |-> !op.wr_en && !op.rd_en)
    else $error("failed command touched the entry RAM");

  a_ram_rsp_ok: assert property (@(posedge clk) disable iff (rst)
    fire && op.rd_en |=> out_valid && out_status == mpf_pkg::ST_OK)
    else $error("RAM read without an ok response");

endmodule

`default_nettype wire

/* bench/multilevel_priority_fifo_test.sv */
// Self-checking bench for the multilevel strict-priority FIFO: random enqueue/dequeue
// traffic with stalls on both channels, checked beat by beat against a local queue model.
// Depends on mpf_pkg, mpf_req_if, mpf_rsp_if and multilevel_priority_fifo.
`timescale 1ns / 100ps

module multilevel_priority_fifo_test;
  import mpf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 220;
  localparam int NUM_PHASES  = 8;

  // Idle profiles
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  typedef struct {
    opcode_t                   op;
    logic [LEVEL_FIELD_W-1:0]  level;
    logic [HANDLE_FIELD_W-1:0] handle;
  } cmd_t;

  typedef struct {
    status_t                   status;
    logic [HANDLE_FIELD_W-1:0] handle;
    logic [LEVEL_FIELD_W-1:0]  level;
  } rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mpf_req_if req_bus ();
  mpf_rsp_if rsp_bus ();

  multilevel_priority_fifo dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  always #1 clk = ~clk;

  // Queue model state
  logic [HANDLE_WIDTH-1:0] slot_mem [LEVELS][DEPTH];
  int head_pos [LEVELS] = '{default: 0};
  int tail_pos [LEVELS] = '{default: 0};
  int fill_cnt [LEVELS] = '{default: 0};

  cmd_t cmd_backlog[$];
  rsp_t due_rsp[$];
  cmd_t cur_cmd;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int issued_cnt     = 0;
  int answered_cnt   = 0;
  int err_cnt        = 0;
  int cycle_cnt      = 0;

  // Apply one command to the queue model and return the response it produces
  function automatic rsp_t ready_queue_step(input cmd_t c);
    rsp_t r;
    int   lv;
    int   sel;
    r.status = ST_OK;
    r.handle = '0;
    r.level  = '0;
    sel      = -1;
    if (c.op == OP_ENQ) begin
      lv = (int'(c.level) >= LEVELS) ? LEVELS - 1 : int'(c.level);
      if (fill_cnt[lv] >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        slot_mem[lv][tail_pos[lv]] = HANDLE_WIDTH'(c.handle);
        tail_pos[lv] = (tail_pos[lv] + 1 >= DEPTH) ? 0 : tail_pos[lv] + 1;
        fill_cnt[lv]++;
      end
    end else begin
      // lowest-numbered nonempty level wins
      for (int i = LEVELS - 1; i >= 0; i--) begin
        if (fill_cnt[i] != 0) sel = i;
      end
      if (sel < 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.handle = HANDLE_FIELD_W'(slot_mem[sel][head_pos[sel]]);
        r.level  = LEVEL_FIELD_W'(sel);
        head_pos[sel] = (head_pos[sel] + 1 >= DEPTH) ? 0 : head_pos[sel] + 1;
        fill_cnt[sel]--;
      end
    end
    return r;
  endfunction

  // Request driver: predicts on each accepted beat, then offers the next one
  always @(posedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        due_rsp.push_back(ready_queue_step(cur_cmd));
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_cmd = cmd_backlog.pop_front();
          req_bus.valid  <= 1'b1;
          req_bus.opcode <= cur_cmd.op;
          req_bus.level  <= cur_cmd.level;
          req_bus.handle <= cur_cmd.handle;
          issued_cnt++;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Response side backpressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Response monitor
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (due_rsp.size() == 0) begin
        $display("%0t: unexpected response beat: status %0d handle %h level %0d",
                 $time, rsp_bus.status, rsp_bus.out_handle, rsp_bus.out_level);
        err_cnt++;
      end else begin
        exp_rsp = due_rsp.pop_front();
        answered_cnt++;
        if (rsp_bus.status !== exp_rsp.status || rsp_bus.out_handle !== exp_rsp.handle ||
            rsp_bus.out_level !== exp_rsp.level) begin
          $display({"%0t: expected status %0d handle %h level %0d, ",
                    "got status %0d handle %h level %0d"},
                   $time, exp_rsp.status, exp_rsp.handle, exp_rsp.level,
                   rsp_bus.status, rsp_bus.out_handle, rsp_bus.out_level);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("multilevel_priority_fifo: mismatch");
      $finish;
    end
  end

  task automatic add_cmd(input opcode_t op, input int lv, input logic [15:0] hdl);
    cmd_t c;
    c.op     = op;
    c.level  = LEVEL_FIELD_W'(lv);
    c.handle = hdl;
    cmd_backlog.push_back(c);
  endtask

  function automatic logic [15:0] pick_handle();
    logic [15:0] h;
    case ($urandom_range(15))
      0:       h = 16'h0000;
      1:       h = 16'hFFFF;
      default: h = 16'($urandom());
    endcase
    return h;
  endfunction

  // Random traffic in bursts: fill one level, often past full, drain, or mixed
  task automatic queue_bursts(input int total);
    int added;
    int kind;
    int n;
    int lv;
    added = 0;
    while (added < total) begin
      kind = $urandom_range(9);
      if (kind < 3) begin
        lv = $urandom_range(LEVELS - 1);
        n  = $urandom_range(12, 20);
        repeat (n) add_cmd(OP_ENQ, lv, pick_handle());
      end else if (kind < 5) begin
        n = $urandom_range(8, 40);
        repeat (n) add_cmd(OP_DEQ, $urandom_range(7), 16'($urandom()));
      end else begin
        n = $urandom_range(5, 30);
        repeat (n) begin
          add_cmd($urandom_range(1) ? OP_DEQ : OP_ENQ, $urandom_range(7), pick_handle());
        end
      end
      added += n;
    end
  endtask

  // Block until every queued command has been answered
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || issued_cnt != answered_cnt);
  endtask

  initial begin
    req_bus.valid  = 1'b0;
    req_bus.opcode = OP_ENQ;
    req_bus.level  = '0;
    req_bus.handle = '0;
    rsp_bus.ready  = 1'b0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty dequeue, field extremes, priority order, empty again
    add_cmd(OP_DEQ, 0, 16'h0000);
    add_cmd(OP_ENQ, 7, 16'hFFFF);
    add_cmd(OP_ENQ, 0, 16'h0000);
    add_cmd(OP_ENQ, 3, 16'hA5A5);
    add_cmd(OP_ENQ, 0, 16'h5A5A);
    add_cmd(OP_ENQ, 4, 16'h1234);
    repeat (5) add_cmd(OP_DEQ, 7, 16'hFFFF);
    add_cmd(OP_DEQ, 0, 16'h0000);
    add_cmd(OP_DEQ, 5, 16'h8001);
    wait_drained();

    // Random phases, each started from a drained pipeline
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        IDLE_SEND: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        IDLE_BOTH: begin send_idle_pct = 21; recv_stall_pct = 21; end
        default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      queue_bursts(PHASE_ITEMS);
      wait_drained();
    end

    // Let any stray response show up
    repeat (8) @(negedge clk);
    if (err_cnt == 0) begin
      $display("multilevel_priority_fifo: match");
    end else begin
      $display("multilevel_priority_fifo: mismatch");
    end
    $finish;
  end

endmodule
